[hw/rtl/tle_pkg.sv]
// Shared types and constants of the terminal line editor.
package tle_pkg;

    localparam int LINE_SIZE   = 64;
    localparam int ADDR_W      = $clog2(LINE_SIZE);
    localparam int CNT_W       = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_ESC     = 8'h1b;
    localparam logic [7:0] CH_BRACKET = 8'h5b;
    localparam logic [7:0] CH_LEFT    = 8'h44;
    localparam logic [7:0] CH_RIGHT   = 8'h43;
    localparam logic [7:0] CH_DEL     = 8'h7f;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TILDE   = 8'h7e;
    localparam logic [7:0] CH_ENTER   = 8'd13;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_CHAR   = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    typedef logic [2:0] t_op;
    localparam t_op OP_STATUS = 3'd0;
    localparam t_op OP_LEFT   = 3'd1;
    localparam t_op OP_RIGHT  = 3'd2;
    localparam t_op OP_ENTER  = 3'd3;
    localparam t_op OP_BKSP   = 3'd4;
    localparam t_op OP_INSERT = 3'd5;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic full;
    } t_queue_status;

endpackage

[hw/rtl/tle_front.sv]
// Front end: takes received bytes, tracks escape sequences and classifies each byte.
module tle_front
    import tle_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // rx_byte
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data,
    input  t_queue_status i_q_status,
    output logic          o_push,
    output t_cmd          o_cmd
);

    localparam logic [1:0] ESC_NORMAL  = 2'd0;
    localparam logic [1:0] ESC_GOT_ESC = 2'd1;
    localparam logic [1:0] ESC_GOT_BRK = 2'd2;

    logic       r_edit_mode;
    logic [1:0] r_esc;
    logic [1:0] n_esc;
    t_op        w_op;
    logic       w_accept;

    assign s_axis_tready = !i_q_status.full;
    assign o_cfg_ready   = 1'b1;
    assign w_accept      = s_axis_tvalid && !i_q_status.full;
    assign o_push        = w_accept && r_edit_mode;
    assign o_cmd.op      = w_op;
    assign o_cmd.data    = s_axis_tdata;

    always_comb begin
        n_esc = ESC_NORMAL;
        w_op  = OP_STATUS;
        if (s_axis_tdata == CH_ESC) begin
            n_esc = ESC_GOT_ESC;
        end else if (r_esc == ESC_GOT_ESC && s_axis_tdata == CH_BRACKET) begin
            n_esc = ESC_GOT_BRK;
        end else if (r_esc == ESC_GOT_BRK && s_axis_tdata == CH_LEFT) begin
            w_op = OP_LEFT;
        end else if (r_esc == ESC_GOT_BRK && s_axis_tdata == CH_RIGHT) begin
            w_op = OP_RIGHT;
        end else if (s_axis_tdata == CH_ENTER) begin
            w_op = OP_ENTER;
        end else if (s_axis_tdata == CH_DEL || s_axis_tdata == CH_BS) begin
            w_op = OP_BKSP;
        end else if (s_axis_tdata >= CH_SPACE && s_axis_tdata <= CH_TILDE) begin
            w_op = OP_INSERT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edit_mode <= 1'b1;
            r_esc       <= ESC_NORMAL;
        end else begin
            if (i_cfg_valid) begin
                r_edit_mode <= i_cfg_data;
            end
            if (o_push) begin
                r_esc <= n_esc;
            end
        end
    end

endmodule

[hw/rtl/tle_queue.sv]
// Short command queue between the front end and the line engine.
module tle_queue
    import tle_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_cmd          i_cmd,
    input  logic          i_pop,
    output t_cmd          o_cmd,
    output t_queue_status o_status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_cmd              r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_QW-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_status.valid = (r_count != '0);
    assign o_status.full  = (r_count == CNT_QW'(QUEUE_DEPTH));
    assign o_cmd          = r_entry[r_rptr];
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && o_status.valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_QW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_QW'(1);
            end
        end
    end

endmodule

[hw/rtl/tle_back.sv]
// Line engine: holds the line buffer, carries out edits and emits results.
module tle_back
    import tle_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_queue_status     i_q_status,
    input  t_cmd              i_cmd,
    output logic              o_pop,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,   // char_value, line_length, cursor_pos, zero pad
    output logic [1:0]        m_axis_tuser,   // kind
    output logic              m_axis_tlast    // is_last
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_FIN   = 3'd2;
    localparam logic [2:0] S_EREAD = 3'd3;
    localparam logic [2:0] S_EOUT  = 3'd4;

    logic [7:0]        r_mem [LINE_SIZE];
    logic [7:0]        r_rdata;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_len, n_len;
    logic [CNT_W-1:0]  r_cur, n_cur;
    logic [CNT_W-1:0]  r_src, n_src;
    logic [ADDR_W-1:0] r_dst, n_dst;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_pend, n_pend;
    logic              r_up, n_up;
    logic              r_ins, n_ins;
    logic [7:0]        r_byte, n_byte;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [ADDR_W-1:0] r_idx, n_idx;

    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_kind, n_kind;
    logic [7:0]        r_char, n_char;
    logic              r_last, n_last;
    logic [CNT_W-1:0]  r_olen, n_olen;
    logic [CNT_W-1:0]  r_ocur, n_ocur;

    logic              w_out_free;
    logic              w_ren;
    logic [ADDR_W-1:0] w_raddr;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [7:0]        w_wdata;
    logic              w_full;
    logic [CNT_W-1:0]  w_base_len;
    logic [CNT_W-1:0]  w_base_cur;
    logic              w_is_last;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {2'b00, r_ocur, r_olen, r_char};
    assign w_full        = (r_len >= CNT_W'(LINE_SIZE));
    assign w_base_len    = w_full ? '0 : r_len;
    assign w_base_cur    = w_full ? '0 : r_cur;
    assign w_is_last     = ({1'b0, r_idx} == (r_n - CNT_W'(1)));

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_cur       = r_cur;
        n_src       = r_src;
        n_dst       = r_dst;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_up        = r_up;
        n_ins       = r_ins;
        n_byte      = r_byte;
        n_n         = r_n;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_kind      = r_kind;
        n_char      = r_char;
        n_last      = r_last;
        n_olen      = r_olen;
        n_ocur      = r_ocur;
        o_pop       = 1'b0;
        w_ren       = 1'b0;
        w_raddr     = r_src[ADDR_W-1:0];
        w_we        = 1'b0;
        w_waddr     = r_dst;
        w_wdata     = r_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_status.valid && w_out_free) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        OP_LEFT: begin
                            if (r_cur != '0) begin
                                n_cur = r_cur - CNT_W'(1);
                            end
                        end
                        OP_RIGHT: begin
                            if (r_cur < r_len) begin
                                n_cur = r_cur + CNT_W'(1);
                            end
                        end
                        OP_BKSP: begin
                            if (r_cur != '0) begin
                                n_src   = r_cur;
                                n_cnt   = r_len - r_cur;
                                n_up    = 1'b1;
                                n_ins   = 1'b0;
                                n_pend  = 1'b0;
                                n_state = S_SHIFT;
                            end
                        end
                        OP_INSERT: begin
                            n_len   = w_base_len;
                            n_cur   = w_base_cur;
                            n_src   = w_base_len - CNT_W'(1);
                            n_cnt   = w_base_len - w_base_cur;
                            n_up    = 1'b0;
                            n_ins   = 1'b1;
                            n_pend  = 1'b0;
                            n_byte  = i_cmd.data;
                            n_state = S_SHIFT;
                        end
                        OP_ENTER: begin
                            if (r_len != '0) begin
                                n_n     = r_len;
                                n_len   = '0;
                                n_cur   = '0;
                                n_idx   = '0;
                                n_state = S_EREAD;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (n_state == S_IDLE) begin
                        n_out_valid = 1'b1;
                        n_kind      = (i_cmd.op == OP_ENTER) ? KIND_EMPTY : KIND_STATUS;
                        n_char      = '0;
                        n_last      = 1'b1;
                        n_olen      = n_len;
                        n_ocur      = n_cur;
                    end
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    w_we = 1'b1;
                end
                if (r_cnt != '0) begin
                    w_ren  = 1'b1;
                    n_pend = 1'b1;
                    n_cnt  = r_cnt - CNT_W'(1);
                    if (r_up) begin
                        n_dst = ADDR_W'(r_src - CNT_W'(1));
                        n_src = r_src + CNT_W'(1);
                    end else begin
                        n_dst = ADDR_W'(r_src + CNT_W'(1));
                        n_src = r_src - CNT_W'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    if (r_ins) begin
                        w_we    = 1'b1;
                        w_waddr = r_cur[ADDR_W-1:0];
                        w_wdata = r_byte;
                        n_len   = r_len + CNT_W'(1);
                        n_cur   = r_cur + CNT_W'(1);
                    end else begin
                        n_len   = r_len - CNT_W'(1);
                        n_cur   = r_cur - CNT_W'(1);
                    end
                    n_out_valid = 1'b1;
                    n_kind      = KIND_STATUS;
                    n_char      = '0;
                    n_last      = 1'b1;
                    n_olen      = n_len;
                    n_ocur      = n_cur;
                    n_state     = S_IDLE;
                end
            end
            S_EREAD: begin
                w_ren   = 1'b1;
                w_raddr = r_idx;
                n_state = S_EOUT;
            end
            S_EOUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_CHAR;
                    n_char      = r_rdata;
                    n_last      = w_is_last;
                    n_olen      = '0;
                    n_ocur      = '0;
                    if (w_is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        w_ren   = 1'b1;
                        w_raddr = r_idx + ADDR_W'(1);
                        n_idx   = r_idx + ADDR_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_ren) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_src  <= n_src;
        r_dst  <= n_dst;
        r_cnt  <= n_cnt;
        r_up   <= n_up;
        r_ins  <= n_ins;
        r_byte <= n_byte;
        r_n    <= n_n;
        r_idx  <= n_idx;
        r_kind <= n_kind;
        r_char <= n_char;
        r_last <= n_last;
        r_olen <= n_olen;
        r_ocur <= n_ocur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_cur       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_cur       <= n_cur;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[hw/rtl/terminal_line_editor_top.sv]
// Top level of the terminal line editor.
//
// Received terminal bytes enter on the s_axis stream, one byte per transaction.
// The front end classifies each byte and tracks escape sequences, then places a
// command in a two-entry queue; the line engine behind it edits a 64-byte line
// buffer held in a single-port-write, registered-read memory.
// Each edit produces one status transaction on m_axis carrying the new length
// and cursor. Enter produces one transaction per line character, tlast on the
// final one, or a single empty-line marker.
// A status result passes through the command queue and then the result register.
// Insert and backspace move the characters right of the cursor through the
// memory port, one per cycle, and then update the length and cursor.
// Enter reads the first character and then emits the line character by character,
// reading each next character as the current one goes to the result register.
// In ymodem mode (cfg register 0) bytes are accepted and dropped.
// Reset empties the line, clears the escape state and selects shell mode.
// When m_axis stalls the result register holds; the queue keeps accepting bytes
// until it is full, after which s_axis_tready goes low.
module terminal_line_editor_top
    import tle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // char_value, line_length, cursor_pos, zero pad
    output logic [1:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast,   // is_last
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data      // edit_mode
);

    t_queue_status w_q_status;
    t_cmd          w_push_cmd;
    t_cmd          w_pop_cmd;
    logic          w_push;
    logic          w_pop;

    tle_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_q_status    (w_q_status),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    tle_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_pop_cmd),
        .o_status (w_q_status)
    );

    tle_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_status    (w_q_status),
        .i_cmd         (w_pop_cmd),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

[sim/tle_line_checker.sv]
// Checker that predicts the terminal line editor's results and compares them with the output stream.
`timescale 1ns / 1ps
module tle_line_checker
    import tle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    input  logic        i_rx_ready,
    input  logic [7:0]  i_rx_data,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [23:0] i_res_data,    // char_value, line_length, cursor_pos, zero pad
    input  logic [1:0]  i_res_user,    // kind
    input  logic        i_res_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    localparam int MAX_REPORTS = 20;

    typedef enum logic [1:0] {ESC_IDLE, ESC_SEEN, ESC_CSI} t_esc;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       ch;
        logic             last;
        logic [CNT_W-1:0] len;
        logic [CNT_W-1:0] cur;
    } t_line_result;

    t_line_result line_result_q[$];
    logic [7:0]   line_buf [LINE_SIZE];
    t_esc         esc_state = ESC_IDLE;
    logic         edit_mode = 1'b1;
    int           line_len = 0;
    int           cursor = 0;
    int           fail_count = 0;
    int           checked = 0;
    int           pending = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_checked    = checked;

    function automatic void queue_result(input logic [1:0] kind, input logic [7:0] ch,
                                         input logic last);
        t_line_result r;
        r.kind = kind;
        r.ch   = ch;
        r.last = last;
        r.len  = CNT_W'(line_len);
        r.cur  = CNT_W'(cursor);
        line_result_q.push_back(r);
    endfunction

    function automatic void edit_line(input logic [7:0] b);
        int n;
        if (!edit_mode) return;
        if (b == CH_ESC) begin
            esc_state = ESC_SEEN;
            queue_result(KIND_STATUS, 8'h00, 1'b1);
            return;
        end
        case (esc_state)
            ESC_SEEN: begin
                esc_state = ESC_IDLE;
                if (b == CH_BRACKET) begin
                    esc_state = ESC_CSI;
                    queue_result(KIND_STATUS, 8'h00, 1'b1);
                    return;
                end
            end
            ESC_CSI: begin
                esc_state = ESC_IDLE;
                if (b == CH_LEFT || b == CH_RIGHT) begin
                    if (b == CH_LEFT && cursor > 0) cursor--;
                    if (b == CH_RIGHT && cursor < line_len) cursor++;
                    queue_result(KIND_STATUS, 8'h00, 1'b1);
                    return;
                end
            end
            default: ;
        endcase
        if (b == CH_ENTER) begin
            n = line_len;
            line_len = 0;
            cursor = 0;
            if (n == 0) begin
                queue_result(KIND_EMPTY, 8'h00, 1'b1);
            end else begin
                for (int i = 0; i < n; i++) queue_result(KIND_CHAR, line_buf[i], i == n - 1);
            end
            return;
        end
        if (b == CH_DEL || b == CH_BS) begin
            if (cursor > 0) begin
                for (int i = cursor; i < line_len; i++) line_buf[i-1] = line_buf[i];
                cursor--;
                line_len--;
            end
        end else if (b >= CH_SPACE && b <= CH_TILDE) begin
            if (line_len >= LINE_SIZE) begin
                line_len = 0;
                cursor = 0;
            end
            for (int i = line_len; i > cursor; i--) line_buf[i] = line_buf[i-1];
            line_buf[cursor] = b;
            line_len++;
            cursor++;
        end
        queue_result(KIND_STATUS, 8'h00, 1'b1);
    endfunction

    function automatic void report(input string field_name, input int exp_v, input int act_v);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name, exp_v, act_v);
    endfunction

    always @(posedge i_clk) begin
        t_line_result exp_r;
        if (!i_rst_n) begin
            edit_mode = 1'b1;
            esc_state = ESC_IDLE;
            line_len = 0;
            cursor = 0;
            line_result_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) edit_mode = i_cfg_data;
            if (i_res_valid && i_res_ready) begin
                checked++;
                if (line_result_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual kind %0d data %0h",
                                 $time, i_res_user, i_res_data);
                end else begin
                    exp_r = line_result_q.pop_front();
                    if (i_res_user != exp_r.kind) report("kind", exp_r.kind, i_res_user);
                    if (i_res_data[7:0] != exp_r.ch) report("char_value", exp_r.ch, i_res_data[7:0]);
                    if (i_res_last != exp_r.last) report("is_last", exp_r.last, i_res_last);
                    if (i_res_data[14:8] != exp_r.len)
                        report("line_length", exp_r.len, i_res_data[14:8]);
                    if (i_res_data[21:15] != exp_r.cur)
                        report("cursor_pos", exp_r.cur, i_res_data[21:15]);
                end
            end
            if (i_rx_valid && i_rx_ready) edit_line(i_rx_data);
        end
        pending = line_result_q.size();
    end

endmodule

[sim/tb_terminal_line_editor_top.sv]
// Testbench top for the terminal line editor: stimulus, stall patterns and the final verdict.
`timescale 1ns / 1ps
module tb_terminal_line_editor_top;
    import tle_pkg::*;

    localparam int ITEMS_PER_PHASE = 25;
    localparam int DRAIN_CYCLES    = 3 * LINE_SIZE + 16;
    localparam int HOLD_CYCLES     = 400;
    localparam int IDLE_GUARD      = 200000;

    localparam logic [7:0] DIRECTED [25] = '{
        CH_ENTER, CH_BS, CH_DEL, 8'h00, 8'hff, CH_SPACE, CH_TILDE,
        CH_ESC, CH_BRACKET, CH_LEFT, 8'h41,
        CH_ESC, CH_BRACKET, CH_RIGHT, CH_ESC, CH_BRACKET, CH_RIGHT,
        CH_ESC, CH_ESC, 8'h71, CH_ESC, CH_BRACKET, 8'h7a, CH_BS, CH_ENTER
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b1;

    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic rx_hold = 1'b0;
    logic shell_on = 1'b1;
    int   shell_bytes = 0;
    int   ymodem_bytes = 0;
    int   fail_count;
    int   pending;
    int   checked;

    terminal_line_editor_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    tle_line_checker line_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (s_axis_tvalid),
        .i_rx_ready   (s_axis_tready),
        .i_rx_data    (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_user   (m_axis_tuser),
        .i_res_last   (m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < 50) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        if (shell_on) shell_bytes++;
        else ymodem_bytes++;
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 && guard < IDLE_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_edit_mode(input logic mode);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        shell_on = mode;
    endtask

    task automatic type_printable(input int count);
        repeat (count) send_byte(8'($urandom_range(CH_TILDE, CH_SPACE)));
    endtask

    task automatic fill_line();
        type_printable(LINE_SIZE);
        case ($urandom_range(3))
            0: type_printable(1);
            1: send_byte(CH_ENTER);
            2: send_byte($urandom_range(1) ? CH_BS : CH_DEL);
            default: send_byte(8'($urandom_range(255, 128)));
        endcase
    endtask

    task automatic ymodem_interlude();
        set_edit_mode(1'b0);
        send_byte(CH_ESC);
        repeat (7) send_byte(8'($urandom_range(255)));
        set_edit_mode(1'b1);
    endtask

    task automatic run_sequence();
        case ($urandom_range(23))
            0, 1, 2, 3, 4, 5, 6, 7, 8: type_printable($urandom_range(12, 1));
            9, 10, 11, 12:
                repeat ($urandom_range(4, 1)) begin
                    send_byte(CH_ESC);
                    send_byte(CH_BRACKET);
                    send_byte($urandom_range(1) ? CH_LEFT : CH_RIGHT);
                end
            13, 14, 15:
                repeat ($urandom_range(3, 1)) send_byte($urandom_range(1) ? CH_BS : CH_DEL);
            16, 17: send_byte(CH_ENTER);
            18, 19: send_byte(8'($urandom_range(255)));
            20: begin
                send_byte(CH_ESC);
                send_byte(8'($urandom_range(255)));
            end
            21, 22: begin
                send_byte(CH_ESC);
                send_byte(CH_BRACKET);
                send_byte(8'($urandom_range(255)));
            end
            default: fill_line();
        endcase
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct);
        int start_count;
        tx_idle_pct <= tx_pct;
        rx_idle_pct <= rx_pct;
        start_count = shell_bytes;
        while (shell_bytes - start_count < ITEMS_PER_PHASE) run_sequence();
    endtask

    initial begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct <= 12;
        rx_idle_pct <= 85;
        @(posedge i_clk);

        foreach (DIRECTED[i]) send_byte(DIRECTED[i]);
        ymodem_interlude();

        run_phase(12, 85);
        ymodem_interlude();
        run_phase(85, 12);
        ymodem_interlude();

        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        fill_line();
        send_byte(CH_ENTER);
        run_phase(0, 0);

        wait_idle();
        $display("Sent %0d bytes in shell mode and %0d in ymodem mode; %0d results compared.",
                 shell_bytes, ymodem_bytes, checked);
        $display("Covered edits, cursor moves, full lines and escapes under three stall patterns.");
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/tle_pkg.sv
hw/rtl/tle_front.sv
hw/rtl/tle_queue.sv
hw/rtl/tle_back.sv
hw/rtl/terminal_line_editor_top.sv
sim/tle_line_checker.sv
sim/tb_terminal_line_editor_top.sv
